// File: sv/acit_pkg.sv
// ----------------------------------------------------------------------------
// acit_pkg
// Shared widths and constants of the active interval concurrency tracker.
// ----------------------------------------------------------------------------
package acit_pkg;

    localparam int START_W = 40;
    localparam int DUR_W   = 31;
    localparam int END_W   = 41;
    localparam int SUM_W   = 48;
    localparam int CNT_W   = 7;
    localparam int AVG_W   = 32;
    localparam int FRAC_W  = 16;
    localparam int DVD_W   = SUM_W + FRAC_W;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 136;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};

endpackage

// File: sv/active_interval_concurrency_tracker_top.sv
// ----------------------------------------------------------------------------
// active_interval_concurrency_tracker_top
// Tracks overlapping tasks in an end-time table and reports load statistics.
// ----------------------------------------------------------------------------
// One word in, one word out. Each task is handled in steps: acceptance, a scan
// that reads every table slot once through the registered-read end-time memory,
// retiring expired tasks and finding the lowest free slot, an insert step that
// inserts the task and updates the counters, and a load of the output register
// that waits while the output is held. A last word adds the bit-serial division
// that forms the Q16.16 average load. The next word is taken once the result is
// loaded into the output register.
module active_interval_concurrency_tracker_top
#(
    parameter int MAX_ACTIVE = 64
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // start_time[39:0], duration[70:40], zero pad [71]
    input  logic [acit_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // active_count[6:0], peak_active[13:7], latest_end[54:14],
    // busy_total[102:55], avg_load_q16[134:103], zero pad [135]
    output logic [acit_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // table_overflow[0]
    output logic                                m_axis_tuser
);

    localparam int AW = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1;
    localparam int CW = $clog2(MAX_ACTIVE + 1);
    localparam logic [AW:0] DEPTH = (AW+1)'(MAX_ACTIVE);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_INS  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]                       state_reg;
    logic [MAX_ACTIVE-1:0]            valid_reg;
    logic [CW-1:0]                    count_reg;
    logic [CW-1:0]                    peak_reg;
    logic [acit_pkg::END_W-1:0]       end_max_reg;
    logic [acit_pkg::SUM_W-1:0]       sum_reg;
    logic [acit_pkg::START_W-1:0]     prev_reg;

    logic [acit_pkg::START_W-1:0]     start_reg;
    logic [acit_pkg::DUR_W-1:0]       dur_reg;
    logic [acit_pkg::END_W-1:0]       end_reg;
    logic                             last_reg;
    logic                             same_reg;

    logic [AW:0]                      rd_idx_reg;
    logic                             chk_reg;
    logic [AW-1:0]                    chk_idx_reg;
    logic                             found_reg;
    logic [AW-1:0]                    slot_reg;
    logic [acit_pkg::AVG_W-1:0]       avg_reg;

    logic                             out_valid_reg;
    logic [acit_pkg::OUT_DATA_W-1:0]  out_data_reg;
    logic                             out_user_reg;

    logic [acit_pkg::END_W-1:0]       mem [MAX_ACTIVE];
    logic [acit_pkg::END_W-1:0]       rd_data_reg;

    logic                             accept;
    logic [acit_pkg::START_W-1:0]     in_start;
    logic [acit_pkg::DUR_W-1:0]       in_dur;
    logic                             chk_valid;
    logic                             retire;
    logic                             mem_we;
    logic [CW-1:0]                    count_ins;
    logic [acit_pkg::END_W-1:0]       end_max_ins;
    logic [acit_pkg::SUM_W:0]         sum_wide;
    logic [acit_pkg::SUM_W-1:0]       sum_ins;
    logic                             div_start;
    logic                             div_done;
    logic [acit_pkg::AVG_W-1:0]       div_q;
    logic                             out_free;
    logic [CW+6:0]                    count_ext;
    logic [CW+6:0]                    peak_ext;

    assign in_start  = s_axis_tdata[acit_pkg::START_W-1:0];
    assign in_dur    = s_axis_tdata[acit_pkg::START_W+acit_pkg::DUR_W-1:acit_pkg::START_W];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;

    assign chk_valid = valid_reg[chk_idx_reg];
    assign retire    = chk_reg && chk_valid && !same_reg && (rd_data_reg <= {1'b0, start_reg});
    assign mem_we    = (state_reg == ST_INS) && found_reg;

    assign count_ins   = found_reg ? count_reg + 1'b1 : count_reg;
    assign end_max_ins = (found_reg && end_reg > end_max_reg) ? end_reg : end_max_reg;
    assign sum_wide    = {1'b0, sum_reg} + (acit_pkg::SUM_W+1)'(dur_reg);
    assign sum_ins     = !found_reg ? sum_reg
                       : sum_wide[acit_pkg::SUM_W] ? acit_pkg::SUM_MAX
                       : sum_wide[acit_pkg::SUM_W-1:0];
    assign div_start   = (state_reg == ST_INS) && last_reg;

    assign count_ext = {7'b0, count_reg};
    assign peak_ext  = {7'b0, peak_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[slot_reg] <= end_reg;
        end
        rd_data_reg <= mem[rd_idx_reg[AW-1:0]];
    end

    acit_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({sum_ins, {acit_pkg::FRAC_W{1'b0}}}),
        .divisor  (end_max_ins),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            count_reg     <= '0;
            peak_reg      <= '0;
            end_max_reg   <= '0;
            sum_reg       <= '0;
            prev_reg      <= '0;
            same_reg      <= 1'b0;
            rd_idx_reg    <= '0;
            chk_reg       <= 1'b0;
            chk_idx_reg   <= '0;
            found_reg     <= 1'b0;
            slot_reg      <= '0;
            avg_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_user_reg  <= 1'b0;
        end
        else
        begin
            if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        same_reg   <= (in_start == prev_reg);
                        if (in_start != prev_reg && count_reg > peak_reg)
                        begin
                            peak_reg <= count_reg;
                        end
                        rd_idx_reg <= '0;
                        chk_reg    <= 1'b0;
                        found_reg  <= 1'b0;
                        state_reg  <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    chk_reg     <= (rd_idx_reg != DEPTH);
                    chk_idx_reg <= rd_idx_reg[AW-1:0];
                    if (rd_idx_reg != DEPTH)
                    begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                    end
                    if (chk_reg)
                    begin
                        if (retire)
                        begin
                            valid_reg[chk_idx_reg] <= 1'b0;
                            if (count_reg != '0)
                            begin
                                count_reg <= count_reg - 1'b1;
                            end
                        end
                        if ((!chk_valid || retire) && !found_reg)
                        begin
                            found_reg <= 1'b1;
                            slot_reg  <= chk_idx_reg;
                        end
                    end
                    else if (rd_idx_reg == DEPTH)
                    begin
                        state_reg <= ST_INS;
                    end
                end
                ST_INS:
                begin
                    if (found_reg)
                    begin
                        valid_reg[slot_reg] <= 1'b1;
                    end
                    count_reg   <= count_ins;
                    end_max_reg <= end_max_ins;
                    sum_reg     <= sum_ins;
                    prev_reg    <= start_reg;
                    if ((same_reg || last_reg) && count_ins > peak_reg)
                    begin
                        peak_reg <= count_ins;
                    end
                    avg_reg   <= '0;
                    state_reg <= last_reg ? ST_DIV : ST_OUT;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        avg_reg   <= (end_max_reg == '0) ? '0 : div_q;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {1'b0, avg_reg, sum_reg, end_max_reg,
                                          peak_ext[6:0], count_ext[6:0]};
                        out_user_reg  <= !found_reg;
                        if (last_reg)
                        begin
                            valid_reg   <= '0;
                            count_reg   <= '0;
                            peak_reg    <= '0;
                            end_max_reg <= '0;
                            sum_reg     <= '0;
                            prev_reg    <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            start_reg <= in_start;
            dur_reg   <= in_dur;
            end_reg   <= {1'b0, in_start} + acit_pkg::END_W'(in_dur);
            last_reg  <= s_axis_tlast;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

// File: sv/acit_div.sv
// ----------------------------------------------------------------------------
// acit_div
// Restoring divider, one quotient bit per cycle, saturating to Q16.16 range.
// ----------------------------------------------------------------------------
module acit_div
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [acit_pkg::DVD_W-1:0]      dividend,
    input  logic [acit_pkg::END_W-1:0]      divisor,
    output logic                            done,
    output logic [acit_pkg::AVG_W-1:0]      quotient
);

    localparam int STEP_W = $clog2(acit_pkg::DVD_W + 1);
    localparam logic [STEP_W-1:0] STEPS = STEP_W'(acit_pkg::DVD_W);

    logic                          busy_reg;
    logic [STEP_W-1:0]             step_reg;
    logic [acit_pkg::END_W-1:0]    rem_reg;
    logic [acit_pkg::DVD_W-1:0]    dvd_reg;
    logic [acit_pkg::DVD_W-1:0]    quo_reg;
    logic [acit_pkg::END_W-1:0]    dvs_reg;
    logic                          done_reg;

    logic [acit_pkg::END_W:0]      trial;
    logic                          fits;
    logic [acit_pkg::END_W:0]      diff;

    assign trial = {rem_reg, dvd_reg[acit_pkg::DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEPS - 1'b1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[acit_pkg::DVD_W-2:0], 1'b0};
            quo_reg <= {quo_reg[acit_pkg::DVD_W-2:0], fits};
            rem_reg <= fits ? diff[acit_pkg::END_W-1:0] : trial[acit_pkg::END_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = (|quo_reg[acit_pkg::DVD_W-1:acit_pkg::AVG_W]) ? acit_pkg::AVG_MAX
                                                                  : quo_reg[acit_pkg::AVG_W-1:0];

endmodule
